/* hw/rtl/vdp_pkg.sv */
// vdp_pkg: shared constants and types for the tile video port and dma engine
// no dependencies
`default_nettype none
package vdp_pkg;
  localparam int unsigned VIDEO_MEM_BYTES = 65536;
  localparam int unsigned ACTIVE_LINES    = 224;
  localparam int unsigned VSCROLL_ENTRIES = 40;
  localparam int unsigned REG_COUNT       = 24;

  localparam logic [2:0] CMD_CTRL   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_HV     = 3'd4;
  localparam logic [2:0] CMD_FRAME  = 3'd5;

  localparam logic [3:0] CODE_VRAM_WR  = 4'h1;
  localparam logic [3:0] CODE_CRAM_WR  = 4'h3;
  localparam logic [3:0] CODE_VSRAM_WR = 4'h5;
  localparam logic [3:0] CODE_VRAM_RD  = 4'h0;
  localparam logic [3:0] CODE_CRAM_RD  = 4'h8;
  localparam logic [3:0] CODE_VSRAM_RD = 4'h4;

  localparam logic [4:0] REG_MODE2   = 5'd1;
  localparam logic [4:0] REG_INC     = 5'd15;
  localparam logic [4:0] REG_LEN_LO  = 5'd19;
  localparam logic [4:0] REG_LEN_HI  = 5'd20;
  localparam logic [4:0] REG_SRC_LO  = 5'd21;
  localparam logic [4:0] REG_SRC_HI  = 5'd22;
  localparam logic [4:0] REG_DMA_SRC = 5'd23;

  localparam logic [1:0] CTRL_REG_WR = 2'b10;
  localparam logic [1:0] DMA_FILL    = 2'd2;
  localparam logic [1:0] DMA_COPY    = 2'd3;

  typedef logic [15:0] word_t;
endpackage
`default_nettype wire

/* hw/rtl/vdp_port_and_dma_engine.sv */
// vdp_port_and_dma_engine: host control/data port with fill and copy dma
// depends on vdp_pkg
// a control, status or counter word passes through the dispatch and output states, a data
// write adds a second write state and a data read three read states; the next word is
// taken in the cycle after its result is taken
// a fill writes each byte in turn, a copy reads then writes each byte, on the single video memory port
// reset: clears video memory one byte per cycle after rst_n,
// and color/scroll memories alongside; no word is accepted meanwhile
`default_nettype none
module vdp_port_and_dma_engine #(
  parameter int unsigned ACTIVE_LINES    = vdp_pkg::ACTIVE_LINES,
  parameter int unsigned VSCROLL_ENTRIES = vdp_pkg::VSCROLL_ENTRIES,
  parameter int unsigned REG_COUNT       = vdp_pkg::REG_COUNT
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // cmd[2:0], word[18:3], line[27:19]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // read_word[15:0]
);
  localparam int unsigned VS_AW = (VSCROLL_ENTRIES > 1) ? $clog2(VSCROLL_ENTRIES) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_WR2   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_RD2   = 4'd5;
  localparam logic [3:0] S_RD3   = 4'd6;
  localparam logic [3:0] S_FILL  = 4'd7;
  localparam logic [3:0] S_CPRD  = 4'd8;
  localparam logic [3:0] S_CPWR  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [7:0]  vram [0:65535];
  logic [11:0] cram [0:63];
  logic [10:0] vsram [0:VSCROLL_ENTRIES-1];
  logic [7:0]  regs_r [0:31];

  logic [3:0]  state_r;
  logic [15:0] clr_r;
  logic [2:0]  cmd_r;
  logic [15:0] word_r;
  logic [8:0]  line_r;
  logic [15:0] addr_r;
  logic [5:0]  code_r;
  logic        second_r, armed_r, frame_r;
  logic [7:0]  hpos_r;
  logic [16:0] cnt_r;
  logic [15:0] src_r;
  logic [15:0] res_r;
  logic        ovalid_r;
  logic [7:0]  hi_r;

  // vram single port
  logic        vwe;
  logic [15:0] va;
  logic [7:0]  vd;
  logic [7:0]  vq_r;
  logic [11:0] cq_r;
  logic [10:0] sq_r;
  logic        cwe, swe;
  logic [5:0]  ca;
  logic [VS_AW-1:0] sa;
  logic [11:0] cd;
  logic [10:0] sd;

  logic [5:0]  widx;
  logic        vs_ok;
  logic [15:0] inc_addr;
  logic [15:0] dlen;
  logic [15:0] swapd;
  logic [8:0]  vline;
  logic [7:0]  hpos_inc;
  logic        copy_go;

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = res_r;

  assign widx = addr_r[6:1];
  assign vs_ok = {26'd0, widx} < VSCROLL_ENTRIES;
  assign inc_addr = addr_r + {8'd0, regs_r[vdp_pkg::REG_INC]};
  assign dlen = {regs_r[vdp_pkg::REG_LEN_HI], regs_r[vdp_pkg::REG_LEN_LO]};
  assign swapd = addr_r[0] ? {word_r[7:0], word_r[15:8]} : word_r;
  assign vline = (line_r > 9'hEA) ? line_r - 9'd6 : line_r;
  assign hpos_inc = hpos_r + 8'h29;
  assign copy_go = second_r && word_r[7] && regs_r[vdp_pkg::REG_MODE2][4] &&
                   (regs_r[vdp_pkg::REG_DMA_SRC][7:6] == vdp_pkg::DMA_COPY);

  always_ff @(posedge clk) begin
    if (vwe) vram[va] <= vd;
    vq_r <= vram[va];
    if (cwe) cram[ca] <= cd;
    cq_r <= cram[ca];
    if (swe) vsram[sa] <= sd;
    sq_r <= vsram[sa];
  end

  always_comb begin
    vwe = 1'b0; va = {addr_r[15:1], 1'b0}; vd = swapd[15:8];
    cwe = 1'b0; ca = widx; cd = word_r[11:0] & 12'hEEE;
    swe = 1'b0; sa = widx[VS_AW-1:0]; sd = word_r[10:0];
    unique case (state_r)
      S_CLEAR: begin
        vwe = 1'b1; va = clr_r; vd = 8'd0;
        cwe = 1'b1; ca = clr_r[5:0]; cd = 12'd0;
        swe = ({10'd0, clr_r[5:0]} < VSCROLL_ENTRIES); sd = 11'd0;
        sa = clr_r[VS_AW-1:0];
      end
      S_DISP: begin
        if (cmd_r == vdp_pkg::CMD_WRITE) begin
          if (armed_r || code_r[3:0] == vdp_pkg::CODE_VRAM_WR) vwe = 1'b1;
          else if (code_r[3:0] == vdp_pkg::CODE_CRAM_WR) cwe = 1'b1;
          else if (code_r[3:0] == vdp_pkg::CODE_VSRAM_WR) swe = vs_ok;
        end
      end
      S_WR2: begin
        vwe = armed_r || (code_r[3:0] == vdp_pkg::CODE_VRAM_WR);
        va = {addr_r[15:1], 1'b1}; vd = swapd[7:0];
      end
      S_RD2: va = {addr_r[15:1], 1'b1};
      S_FILL: begin
        vwe = 1'b1; va = addr_r ^ 16'd1; vd = hi_r;
      end
      S_CPRD: va = src_r ^ 16'd1;
      S_CPWR: begin
        vwe = 1'b1; va = addr_r ^ 16'd1; vd = vq_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= 16'd0; addr_r <= 16'd0; code_r <= 6'd0;
      second_r <= 1'b0; armed_r <= 1'b0; frame_r <= 1'b0; hpos_r <= 8'd0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 32; i++) regs_r[i] <= 8'd0;
    end else begin
      if (state_r == S_OUT) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 16'd1;
          if (clr_r == 16'hFFFF) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          cmd_r <= in_tdata[2:0]; word_r <= in_tdata[18:3]; line_r <= in_tdata[27:19];
          state_r <= S_DISP;
        end
        S_DISP: begin
          case (cmd_r)
            vdp_pkg::CMD_CTRL: begin
              res_r <= 16'd0;
              state_r <= copy_go ? S_CPRD : S_OUT;
              if (!second_r) begin
                if (word_r[15:14] == vdp_pkg::CTRL_REG_WR) begin
                  if ({27'd0, word_r[12:8]} < REG_COUNT) regs_r[word_r[12:8]] <= word_r[7:0];
                end else begin
                  addr_r[13:0] <= word_r[13:0];
                  code_r[1:0] <= word_r[15:14];
                  second_r <= 1'b1;
                end
              end else begin
                second_r <= 1'b0;
                addr_r[15:14] <= word_r[1:0];
                code_r[5:2] <= word_r[7:4];
                if (word_r[7] && regs_r[vdp_pkg::REG_MODE2][4]) begin
                  if (regs_r[vdp_pkg::REG_DMA_SRC][7:6] == vdp_pkg::DMA_FILL) armed_r <= 1'b1;
                  else if (regs_r[vdp_pkg::REG_DMA_SRC][7:6] == vdp_pkg::DMA_COPY) begin
                    cnt_r <= (dlen == 16'd0) ? 17'h10000 : {1'b0, dlen};
                    src_r <= {regs_r[vdp_pkg::REG_SRC_HI], regs_r[vdp_pkg::REG_SRC_LO]};
                  end
                end
              end
            end
            vdp_pkg::CMD_WRITE: begin
              res_r <= 16'd0;
              second_r <= 1'b0;
              state_r <= S_WR2;
              hi_r <= word_r[15:8];
            end
            vdp_pkg::CMD_READ: begin
              second_r <= 1'b0;
              state_r <= S_RD1;
            end
            vdp_pkg::CMD_STATUS: begin
              res_r <= 16'h3600 | (({23'd0, line_r} >= ACTIVE_LINES ||
                        !regs_r[vdp_pkg::REG_MODE2][6]) ? 16'h0008 : 16'h0) |
                       (frame_r ? 16'h0080 : 16'h0);
              second_r <= 1'b0; frame_r <= 1'b0;
              state_r <= S_OUT;
            end
            vdp_pkg::CMD_HV: begin
              hpos_r <= hpos_inc;
              res_r <= {vline[7:0], hpos_inc};
              state_r <= S_OUT;
            end
            vdp_pkg::CMD_FRAME: begin
              frame_r <= 1'b1;
              res_r <= 16'd0;
              state_r <= S_OUT;
            end
            default: begin
              res_r <= 16'd0;
              state_r <= S_OUT;
            end
          endcase
        end
        S_WR2: begin
          addr_r <= inc_addr;
          if (armed_r) begin
            armed_r <= 1'b0;
            cnt_r <= (dlen == 16'd0) ? 17'h10000 : {1'b0, dlen};
            state_r <= S_FILL;
          end else state_r <= S_OUT;
        end
        S_FILL: begin
          addr_r <= inc_addr;
          cnt_r <= cnt_r - 17'd1;
          if (cnt_r == 17'd1) begin
            regs_r[vdp_pkg::REG_LEN_LO] <= 8'd0; regs_r[vdp_pkg::REG_LEN_HI] <= 8'd0;
            state_r <= S_OUT;
          end
        end
        S_CPRD: state_r <= S_CPWR;
        S_CPWR: begin
          addr_r <= inc_addr;
          src_r <= src_r + 16'd1;
          cnt_r <= cnt_r - 17'd1;
          if (cnt_r == 17'd1) begin
            regs_r[vdp_pkg::REG_LEN_LO] <= 8'd0; regs_r[vdp_pkg::REG_LEN_HI] <= 8'd0;
            regs_r[vdp_pkg::REG_SRC_LO] <= src_r[7:0] + 8'd1;
            regs_r[vdp_pkg::REG_SRC_HI] <= src_r[15:8] + {7'd0, &src_r[7:0]};
            state_r <= S_OUT;
          end else state_r <= S_CPRD;
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          hi_r <= vq_r;
          state_r <= S_RD3;
        end
        S_RD3: begin
          case (code_r[3:0])
            vdp_pkg::CODE_VRAM_RD:  res_r <= {hi_r, vq_r};
            vdp_pkg::CODE_CRAM_RD:  res_r <= {4'd0, cq_r};
            vdp_pkg::CODE_VSRAM_RD: res_r <= vs_ok ? {5'd0, sq_r} : 16'd0;
            default: res_r <= 16'd0;
          endcase
          addr_r <= inc_addr;
          state_r <= S_OUT;
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !ovalid_r) else $error("accept while result pending");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> ovalid_r) else $error("result lost");
  a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready) else $error("accept during clear");
endmodule
`default_nettype wire
